// File: rtl/core/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded deque with positional insert.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // Fixed field widths of the stream payloads.
   localparam int OPCODE_W   = 3;
   localparam int VALUE_W    = 32;
   localparam int POSITION_W = 5;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 5;

   localparam int REQ_FIELDS_W = OPCODE_W + VALUE_W + POSITION_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = VALUE_W + STATUS_W + COUNT_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_PUSH_AT    = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef enum logic [1:0] {
      WHERE_FRONT,
      WHERE_BACK,
      WHERE_INDEX
   } where_type;

   // Command from the controller to the datapath.
   typedef struct packed {
      logic                go;
      logic                insert;
      logic                extract;
      where_type           where;
      logic [STATUS_W-1:0] status;
   } cmd_type;

   // Occupancy flags from the datapath to the controller.
   typedef struct packed {
      logic full;
      logic empty;
   } stat_type;

endpackage

`default_nettype wire

// File: rtl/core/bdq_ctrl.sv
// ----------------------------------------------------------------------------
// bdq_ctrl
// Handshake controller: decodes the opcode against the occupancy flags and
// tracks whether a result item is waiting in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_ctrl (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire  [bdq_pkg::OPCODE_W-1:0] opcode,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   input  bdq_pkg::stat_type            stat,
   output bdq_pkg::cmd_type             cmd
);
   import bdq_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_HOLD
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign rsp_tvalid = (state_ff == S_HOLD);
   assign req_tready = (state_ff == S_IDLE) || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd         = '0;
      cmd.where   = WHERE_FRONT;
      cmd.status  = ST_OK;
      cmd.go      = accept;
      case (opcode)
         OP_PUSH_FRONT, OP_PUSH_BACK, OP_PUSH_AT: begin
            if (opcode == OP_PUSH_BACK) begin
               cmd.where = WHERE_BACK;
            end else if (opcode == OP_PUSH_AT) begin
               cmd.where = WHERE_INDEX;
            end
            if (stat.full) begin
               cmd.status = ST_FULL;
            end else begin
               cmd.insert = 1'b1;
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (opcode == OP_POP_BACK) begin
               cmd.where = WHERE_BACK;
            end
            if (stat.empty) begin
               cmd.status = ST_EMPTY;
            end else begin
               cmd.extract = 1'b1;
            end
         end
         default: begin
            cmd.status = ST_OK;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (rsp_tready && !accept) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/bdq_datapath.sv
// ----------------------------------------------------------------------------
// bdq_datapath
// Shifting register array with its fill count and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_datapath #(
   parameter int DEPTH      = bdq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire                            clock,
   input  wire                            reset,
   input  bdq_pkg::cmd_type               cmd,
   input  wire  [bdq_pkg::VALUE_W-1:0]    value,
   input  wire  [bdq_pkg::POSITION_W-1:0] position,
   output bdq_pkg::stat_type              stat,
   output logic [bdq_pkg::VALUE_W-1:0]    extracted,
   output logic [bdq_pkg::STATUS_W-1:0]   status,
   output logic [bdq_pkg::COUNT_W-1:0]    count
);
   import bdq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);
   localparam int PW = (CW > POSITION_W) ? CW : POSITION_W;

   logic [DATA_WIDTH-1:0] slots_ff [DEPTH];
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;
   logic [VALUE_W-1:0]    extracted_ff;
   logic [STATUS_W-1:0]   status_ff;
   logic [CW-1:0]         idx;
   logic [PW-1:0]         pos_ext;
   logic [PW-1:0]         cnt_ext;
   logic [CW-1:0]         last;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [DATA_WIDTH-1:0] rd_data;
   logic [VALUE_W-1:0]    rd_wide;

   assign stat.full  = (count_ff == CW'(DEPTH));
   assign stat.empty = (count_ff == '0);

   assign pos_ext = PW'(position);
   assign cnt_ext = PW'(count_ff);
   assign last    = count_ff - 1'b1;

   // Target slot of an insert; out-of-range positions clamp to the back end.
   always_comb begin
      idx = '0;
      case (cmd.where)
         WHERE_FRONT: idx = '0;
         WHERE_BACK:  idx = count_ff;
         WHERE_INDEX: begin
            if (position == '0 || count_ff == '0) begin
               idx = '0;
            end else if (pos_ext >= cnt_ext) begin
               idx = count_ff;
            end else begin
               idx = pos_ext[CW-1:0];
            end
         end
         default: idx = '0;
      endcase
   end

   generate
      if (DATA_WIDTH == VALUE_W) begin : g_same
         assign wr_data = value;
         assign rd_wide = rd_data;
      end else if (DATA_WIDTH < VALUE_W) begin : g_narrow
         assign wr_data = value[DATA_WIDTH-1:0];
         assign rd_wide = {{(VALUE_W - DATA_WIDTH){rd_data[DATA_WIDTH-1]}}, rd_data};
      end else begin : g_wide
         assign wr_data = {{(DATA_WIDTH - VALUE_W){value[VALUE_W-1]}}, value};
         assign rd_wide = rd_data[VALUE_W-1:0];
      end
   endgenerate

   assign rd_data = (cmd.where == WHERE_BACK) ? slots_ff[last[AW-1:0]] : slots_ff[0];

   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.extract) begin
         count_in = last;
      end
   end

   // Each slot takes its lower neighbor on an insert shift and its upper
   // neighbor on a front extract; entries at or above the count are don't-care.
   always_ff @(posedge clock) begin
      if (cmd.go && cmd.insert) begin
         for (int i = 0; i < DEPTH; i++) begin
            if (CW'(i) == idx) begin
               slots_ff[i] <= wr_data;
            end else if (i > 0 && CW'(i) > idx) begin
               slots_ff[i] <= slots_ff[(i > 0) ? i - 1 : 0];
            end
         end
      end else if (cmd.go && cmd.extract && cmd.where == WHERE_FRONT) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            slots_ff[i] <= slots_ff[i + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.go) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.go) begin
         extracted_ff <= cmd.extract ? rd_wide : '0;
         status_ff    <= cmd.status;
      end
   end

   assign extracted = extracted_ff;
   assign status    = status_ff;
   assign count     = COUNT_W'(count_ff);

endmodule

`default_nettype wire

// File: rtl/core/bounded_deque_with_positional_insert.sv
// Response: an accepted request item's response item is valid in the next cycle.
// Throughput: one item per cycle while each response is taken; the array shifts all entries at once
// and the output register lets a new item enter while a response is taken.
// Reset: synchronous, active high; clears the fill count and the output valid.
// Stored values are not cleared; only entries below the count are ever read.
// ----------------------------------------------------------------------------
// bounded_deque_with_positional_insert
// Bounded double-ended queue with insert before a given index.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_deque_with_positional_insert #(
   parameter int DEPTH      = bdq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_tvalid,
   output logic                           req_tready,
   // opcode [2:0], value [34:3], position [39:35]
   input  wire  [bdq_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   // extracted [31:0], status [33:32], count [38:34], zero [39]
   output logic [bdq_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import bdq_pkg::*;

   localparam int POS_LO = OPCODE_W + VALUE_W;

   cmd_type                cmd;
   stat_type               stat;
   logic [OPCODE_W-1:0]    opcode;
   logic [VALUE_W-1:0]     value;
   logic [POSITION_W-1:0]  position;
   logic [VALUE_W-1:0]     extracted;
   logic [STATUS_W-1:0]    status;
   logic [COUNT_W-1:0]     count;

   assign opcode   = req_tdata[OPCODE_W-1:0];
   assign value    = req_tdata[OPCODE_W +: VALUE_W];
   assign position = req_tdata[POS_LO +: POSITION_W];

   bdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .opcode     (opcode),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bdq_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .value     (value),
      .position  (position),
      .stat      (stat),
      .extracted (extracted),
      .status    (status),
      .count     (count)
   );

   assign rsp_tdata = RSP_DATA_W'({count, status, extracted});

endmodule

`default_nettype wire

// File: sim/tb_bounded_deque_with_positional_insert.sv
// ----------------------------------------------------------------------------
// tb_bounded_deque_with_positional_insert
// Self-checking bench for the bounded deque with positional insert. A directed
// opening walks the empty, full and mid-sequence insert cases, then bursts of
// random operations lean toward filling or draining the store. Every accepted
// item is run through a local deque predictor, and every response is checked
// against it in order, under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bounded_deque_with_positional_insert;
   import bdq_pkg::*;

   localparam int DEPTH          = DEPTH_DEFAULT;
   localparam int RANDOM_PER_PHASE = 300;
   localparam int STALL_LIMIT    = 5000;
   localparam int MAX_REPORTS    = 100;

   // Opcodes that the block treats as no operation.
   localparam logic [OPCODE_W-1:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_UNUSED_LAST  = 3'd7;

   // Packed to match req_tdata: opcode in the lowest bits, position on top.
   typedef struct packed {
      logic [POSITION_W-1:0]     position;
      logic signed [VALUE_W-1:0] value;
      logic [OPCODE_W-1:0]       opcode;
   } deque_req_type;

   // Packed to match rsp_tdata: extracted lowest, one zero pad bit on top.
   typedef struct packed {
      logic                      pad;
      logic [COUNT_W-1:0]        count;
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] extracted;
   } deque_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // opcode, value, position
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // extracted, status, count, zero

   deque_req_type pending_req_q[$];
   deque_rsp_type expected_rsp_q[$];

   // Predictor state.
   logic [VALUE_W-1:0] shadow_slots [DEPTH];
   int                 shadow_count = 0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int mismatches = 0;
   int responses_seen = 0;
   int items_accepted = 0;
   int full_refusals = 0;
   int empty_refusals = 0;
   int stall_cycles = 0;

   bounded_deque_with_positional_insert dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Applies one operation to the shadow deque and returns its response.
   task automatic deque_apply(input deque_req_type rq, output deque_rsp_type rs);
      int slot;
      int i;
      rs = '0;
      rs.status = ST_OK;
      case (rq.opcode)
         OP_PUSH_FRONT, OP_PUSH_BACK, OP_PUSH_AT: begin
            if (shadow_count >= DEPTH) begin
               rs.status = ST_FULL;
            end else begin
               if (rq.opcode == OP_PUSH_FRONT) begin
                  slot = 0;
               end else if (rq.opcode == OP_PUSH_BACK) begin
                  slot = shadow_count;
               end else if (rq.position >= shadow_count) begin
                  // Also covers an empty store, where the count is zero.
                  slot = shadow_count;
               end else begin
                  slot = rq.position;
               end
               for (i = shadow_count; i > slot; i--)
                  shadow_slots[i] = shadow_slots[i-1];
               shadow_slots[slot] = rq.value;
               shadow_count++;
            end
         end
         OP_POP_FRONT: begin
            if (shadow_count == 0) begin
               rs.status = ST_EMPTY;
            end else begin
               rs.extracted = shadow_slots[0];
               for (i = 0; i + 1 < shadow_count; i++)
                  shadow_slots[i] = shadow_slots[i+1];
               shadow_count--;
            end
         end
         OP_POP_BACK: begin
            if (shadow_count == 0) begin
               rs.status = ST_EMPTY;
            end else begin
               rs.extracted = shadow_slots[shadow_count-1];
               shadow_count--;
            end
         end
         default: begin
         end
      endcase
      rs.count = shadow_count[COUNT_W-1:0];
   endtask

   task automatic queue_op(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] val,
                           input logic [POSITION_W-1:0] pos);
      deque_req_type rq;
      rq.opcode = op;
      rq.value = val;
      rq.position = pos;
      pending_req_q.push_back(rq);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 19))
         0: return '0;
         1: return '1;
         2: return 32'h7fff_ffff;
         3: return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Bursts that lean toward inserts or extracts, or mix them evenly, so that the store keeps
   // swinging between empty and full.
   task automatic queue_random_ops(input int n);
      int left;
      int burst;
      int insert_pct;
      int roll;
      logic [OPCODE_W-1:0] op;
      left = n;
      while (left > 0) begin
         burst = $urandom_range(4, 40);
         case ($urandom_range(0, 2))
            0: insert_pct = 85;
            1: insert_pct = 15;
            default: insert_pct = 50;
         endcase
         for (int k = 0; k < burst && left > 0; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
               op = OPCODE_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
            end else if ($urandom_range(0, 99) < insert_pct) begin
               case ($urandom_range(0, 3))
                  0: op = OP_PUSH_FRONT;
                  1: op = OP_PUSH_BACK;
                  default: op = OP_PUSH_AT;
               endcase
            end else begin
               op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
            end
            queue_op(op, pick_value(), POSITION_W'($urandom_range(0, DEPTH)));
            left--;
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_req_q.size() != 0 || req_tvalid || expected_rsp_q.size() != 0)
         @(negedge clock);
   endtask

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_req_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_tdata <= pending_req_q.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Response checker, then prediction for the item accepted at this edge.
   always @(posedge clock) begin
      deque_rsp_type got;
      deque_rsp_type want;
      deque_rsp_type predicted;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            responses_seen++;
            if (expected_rsp_q.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: unexpected response, expected none, actual %h",
                           $time, rsp_tdata);
            end else begin
               want = expected_rsp_q.pop_front();
               if (got.extracted !== want.extracted) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("%0t: extracted mismatch, expected %0d, actual %0d",
                              $time, want.extracted, got.extracted);
               end
               if (got.status !== want.status) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("%0t: status mismatch, expected %0d, actual %0d",
                              $time, want.status, got.status);
               end
               if (got.count !== want.count) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("%0t: count mismatch, expected %0d, actual %0d",
                              $time, want.count, got.count);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            deque_apply(deque_req_type'(req_tdata), predicted);
            expected_rsp_q.push_back(predicted);
            items_accepted++;
            if (predicted.status == ST_FULL) full_refusals++;
            if (predicted.status == ST_EMPTY) empty_refusals++;
         end
      end
   end

   // Watchdog on cycles where work is outstanding but nothing moves.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (pending_req_q.size() == 0 && !req_tvalid && expected_rsp_q.size() == 0)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("Regression FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int send_mix [4];
      int recv_mix [4];
      logic [POSITION_W-1:0] fill_pos [10];
      send_mix = '{0, 68, 0, 24};
      recv_mix = '{0, 0, 68, 24};
      fill_pos = '{5'd1, 5'd3, 5'd7, 5'd15, 5'd4, 5'd8, 5'd2, 5'd12, 5'd6, 5'd9};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed opening: refusals on empty, every insert flavor, unused
      // opcodes, then fill to the limit and refuse one more.
      queue_op(OP_POP_FRONT, 32'h1234_5678, 5'd0);
      queue_op(OP_POP_BACK, 32'h1234_5678, 5'd0);
      queue_op(OP_PUSH_AT, '0, 5'd5);
      queue_op(OP_PUSH_FRONT, 32'h7fff_ffff, 5'd31);
      queue_op(OP_PUSH_BACK, 32'h8000_0000, 5'd0);
      queue_op(OP_PUSH_AT, '1, 5'd0);
      queue_op(OP_PUSH_AT, 32'h5555_aaaa, 5'd16);
      queue_op(OP_PUSH_AT, 32'haaaa_5555, 5'd2);
      for (int op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST; op++)
         queue_op(OPCODE_W'(op), 32'hdead_beef, 5'd1);
      foreach (fill_pos[k])
         queue_op(OP_PUSH_AT, $urandom, fill_pos[k]);
      queue_op(OP_PUSH_BACK, 32'h0bad_f00d, 5'd0);
      queue_op(OP_POP_FRONT, '0, 5'd0);
      queue_op(OP_POP_BACK, '0, 5'd0);
      wait_drained();

      foreach (send_mix[p]) begin
         send_idle_pct = send_mix[p];
         recv_stall_pct = recv_mix[p];
         queue_random_ops(RANDOM_PER_PHASE);
         wait_drained();
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (5) @(posedge clock);

      $display("Ran %0d operations and checked %0d responses over four idling mixes.",
               items_accepted, responses_seen);
      $display("Saw %0d inserts refused as full and %0d extracts refused as empty.",
               full_refusals, empty_refusals);
      if (mismatches == 0 && expected_rsp_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d responses never arrived", mismatches,
                  expected_rsp_q.size());
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
